// ===== rtl/tsd_pkg.sv =====
`default_nettype none

package tsd_pkg;

   // Word widths of the fixed-point datapath.
   localparam int WORD_BITS      = 32;
   localparam int REG_BITS       = WORD_BITS - 1;
   localparam int MAG_BITS       = WORD_BITS;
   localparam int SQ_BITS        = 2 * MAG_BITS;
   localparam int ROOT_BITS      = SQ_BITS / 2;
   localparam int REM_BITS       = ROOT_BITS + 2;
   localparam int SIDE_BITS      = WORD_BITS + 2;
   localparam int CSR_INDEX_BITS = 2;

   // Register reset values, fixed point with sixteen fraction bits.
   localparam logic [REG_BITS-1:0] RESET_INNER = REG_BITS'(32768);
   localparam logic [REG_BITS-1:0] RESET_OUTER = REG_BITS'(65536);
   localparam logic [REG_BITS-1:0] RESET_HALF  = REG_BITS'(65536);

   // Register indexes on the configuration port.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_INNER = 2'd0,
      CSR_OUTER = 2'd1,
      CSR_HALF  = 2'd2
   } csr_index_type;

   // Tube geometry as held in the configuration registers.
   typedef struct packed {
      logic [REG_BITS-1:0] inner;
      logic [REG_BITS-1:0] outer;
      logic [REG_BITS-1:0] half;
   } cfg_type;

   // Valid bit and the signed value that rides along a pipeline section.
   typedef struct packed {
      logic                        valid;
      logic signed [SIDE_BITS-1:0] side;
   } tag_type;

endpackage

`default_nettype wire

// ===== rtl/tsd_if.sv =====
`default_nettype none

// Query point channel.
interface tsd_req_if;
   import tsd_pkg::*;
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] point_x;
   logic signed [WORD_BITS-1:0] point_y;
   logic signed [WORD_BITS-1:0] point_z;

   modport source (output valid, output point_x, output point_y, output point_z, input ready);
   modport sink (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

// Distance result channel.
interface tsd_rsp_if;
   import tsd_pkg::*;
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] signed_distance;

   modport source (output valid, output signed_distance, input ready);
   modport sink (input valid, input signed_distance, output ready);
endinterface

// Configuration write channel.
interface tsd_csr_if;
   import tsd_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [REG_BITS-1:0]       data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/tsd_csr.sv =====
`default_nettype none

module tsd_csr (
   input  logic             clock,
   input  logic             reset,
   tsd_csr_if.sink          csr,
   output tsd_pkg::cfg_type cfg
);
   import tsd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken; an index beyond the register list is dropped.
   assign csr.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (csr.index)
            CSR_INNER: cfg_in.inner = csr.data;
            CSR_OUTER: cfg_in.outer = csr.data;
            CSR_HALF:  cfg_in.half  = csr.data;
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inner <= RESET_INNER;
         cfg_ff.outer <= RESET_OUTER;
         cfg_ff.half  <= RESET_HALF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/tsd_sumsq.sv =====
`default_nettype none

// Two-stage sum of squares: one multiplier per operand, then the wide add.
module tsd_sumsq (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  tsd_pkg::tag_type               in_tag,
   input  logic [tsd_pkg::MAG_BITS-1:0]   a,
   input  logic [tsd_pkg::MAG_BITS-1:0]   b,
   output tsd_pkg::tag_type               out_tag,
   output logic [tsd_pkg::SQ_BITS-1:0]    sum
);
   import tsd_pkg::*;

   logic [SQ_BITS-1:0] sq_a_ff, sq_a_in;
   logic [SQ_BITS-1:0] sq_b_ff, sq_b_in;
   logic [SQ_BITS-1:0] sum_ff, sum_in;
   tag_type            tag1_ff, tag2_ff;

   // Squares of the two magnitudes.
   assign sq_a_in = a * a;
   assign sq_b_in = b * b;

   // Both squares are at most 2^(2*MAG_BITS-2), so the sum cannot carry out.
   assign sum_in = sq_a_ff + sq_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.valid <= 1'b0;
         tag2_ff.valid <= 1'b0;
      end else if (en) begin
         tag1_ff <= in_tag;
         tag2_ff <= tag1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_a_ff <= sq_a_in;
         sq_b_ff <= sq_b_in;
         sum_ff  <= sum_in;
      end
   end

   assign out_tag = tag2_ff;
   assign sum     = sum_ff;

endmodule

`default_nettype wire

// ===== rtl/tsd_sqrt.sv =====
`default_nettype none

// Pipelined floor square root, one result bit per stage.
module tsd_sqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  tsd_pkg::tag_type               in_tag,
   input  logic [tsd_pkg::SQ_BITS-1:0]    radicand,
   output tsd_pkg::tag_type               out_tag,
   output logic [tsd_pkg::ROOT_BITS-1:0]  root
);
   import tsd_pkg::*;

   logic [SQ_BITS-1:0]   rad_ff  [ROOT_BITS];
   logic [SQ_BITS-1:0]   rad_in  [ROOT_BITS];
   logic [REM_BITS-1:0]  rem_ff  [ROOT_BITS];
   logic [REM_BITS-1:0]  rem_in  [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_ff [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_in [ROOT_BITS];
   tag_type              tag_ff  [ROOT_BITS];
   tag_type              tag_in  [ROOT_BITS];

   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_step
      logic [SQ_BITS-1:0]   rad_prev;
      logic [REM_BITS-1:0]  rem_prev;
      logic [ROOT_BITS-1:0] root_prev;
      tag_type              tag_prev;
      logic [REM_BITS+1:0]  shifted;
      logic [REM_BITS+1:0]  trial;
      logic                 take;

      if (k == 0) begin : g_first
         assign rad_prev  = radicand;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign tag_prev  = in_tag;
      end else begin : g_next
         assign rad_prev  = rad_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign tag_prev  = tag_ff[k-1];
      end

      // Bring down the next two radicand bits and try the next root bit.
      assign shifted = {rem_prev, rad_prev[SQ_BITS-1 -: 2]};
      assign trial   = (REM_BITS + 2)'({root_prev, 2'b01});
      assign take    = shifted >= trial;

      // The remainder stays at most twice the partial root, so it fits.
      assign rem_in[k]  = take ? REM_BITS'(shifted - trial) : shifted[REM_BITS-1:0];
      assign root_in[k] = {root_prev[ROOT_BITS-2:0], take};
      assign rad_in[k]  = rad_prev << 2;
      assign tag_in[k]  = tag_prev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ROOT_BITS; k++) begin
            tag_ff[k].valid <= 1'b0;
         end
      end else if (en) begin
         for (int k = 0; k < ROOT_BITS; k++) begin
            tag_ff[k] <= tag_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < ROOT_BITS; k++) begin
            rad_ff[k]  <= rad_in[k];
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
         end
      end
   end

   assign out_tag = tag_ff[ROOT_BITS-1];
   assign root    = root_ff[ROOT_BITS-1];

endmodule

`default_nettype wire

// ===== rtl/tube_signed_distance_core.sv =====
`default_nettype none

// Signed distance from a query point to a hollow capped tube about the z axis, all
// values Q16.16. One point is taken every cycle unless the output stalls; a result
// passes one input stage, two stages of squaring and summing, 32 stages of the first
// square root (rho), two stages forming the radial and height excesses, two more of
// squaring and summing, 32 stages of the second square root and the output register.
// The two bit-per-stage square roots make up most of the depth. The whole pipeline
// advances together; when a result sits unaccepted at the output, every stage holds
// and req.ready drops until it is taken. The configuration port is always ready,
// resets to inner 0.5, outer 1.0 and half height 1.0, ignores writes beyond index 2,
// and must be written only while no transaction is in flight, unchecked by the core.
module tube_signed_distance_core (
   input  logic     clock,
   input  logic     reset,
   tsd_req_if.sink  req,
   tsd_rsp_if.source rsp,
   tsd_csr_if.sink  csr
);
   import tsd_pkg::*;

   localparam logic signed [SIDE_BITS-1:0] WMAX = SIDE_BITS'((64'sd1 <<< (WORD_BITS - 1)) - 1);
   localparam logic signed [SIDE_BITS-1:0] WMIN = -WMAX - SIDE_BITS'(1);
   localparam logic signed [SIDE_BITS-1:0] LIM  = SIDE_BITS'(64'sd1 <<< (WORD_BITS - 1));

   function automatic logic [MAG_BITS-1:0] magnitude(input logic signed [WORD_BITS-1:0] v);
      return v[WORD_BITS-1] ? MAG_BITS'(-v) : MAG_BITS'(v);
   endfunction

   cfg_type cfg;
   logic    en;

   tsd_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .cfg   (cfg)
   );

   // Global advance: move whenever the output register is empty or being taken.
   logic                         out_valid_ff;
   logic signed [WORD_BITS-1:0]  dist_ff, dist_in;

   assign en        = !out_valid_ff || rsp.ready;
   assign req.ready = en;

   // Input stage: magnitudes of x and y, height excess |z| minus the half height.
   tag_type                      in_tag_ff, in_tag_in;
   logic [MAG_BITS-1:0]          mx_ff, mx_in;
   logic [MAG_BITS-1:0]          my_ff, my_in;

   always_comb begin
      mx_in           = magnitude(req.point_x);
      my_in           = magnitude(req.point_y);
      in_tag_in.valid = req.valid;
      in_tag_in.side  = $signed({2'b00, magnitude(req.point_z)})
                        - $signed({3'b000, cfg.half});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_tag_ff.valid <= 1'b0;
      end else if (en) begin
         in_tag_ff <= in_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mx_ff <= mx_in;
         my_ff <= my_in;
      end
   end

   // Radial distance rho = floor(sqrt(x*x + y*y)).
   tag_type              rsq_tag;
   logic [SQ_BITS-1:0]   rsq;
   tag_type              rho_tag;
   logic [ROOT_BITS-1:0] rho;

   tsd_sumsq u_rad_sumsq (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_tag  (in_tag_ff),
      .a       (mx_ff),
      .b       (my_ff),
      .out_tag (rsq_tag),
      .sum     (rsq)
   );

   tsd_sqrt u_rad_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_tag   (rsq_tag),
      .radicand (rsq),
      .out_tag  (rho_tag),
      .root     (rho)
   );

   // Radial excess: distance past the nearer wall of the annulus.
   logic                         ex_valid_ff;
   logic signed [SIDE_BITS-1:0]  qx_ff, qx_in;
   logic signed [SIDE_BITS-1:0]  qz_ff;
   logic [SIDE_BITS-1:0]         twice_rho;
   logic [SIDE_BITS-1:0]         wall_sum;
   logic signed [SIDE_BITS-1:0]  rho_s;

   always_comb begin
      rho_s     = $signed({2'b00, rho});
      twice_rho = {1'b0, rho, 1'b0};
      wall_sum  = {3'b000, cfg.inner} + {3'b000, cfg.outer};
      if (twice_rho >= wall_sum) begin
         qx_in = rho_s - $signed({3'b000, cfg.outer});
      end else begin
         qx_in = $signed({3'b000, cfg.inner}) - rho_s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff <= 1'b0;
      end else if (en) begin
         ex_valid_ff <= rho_tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         qx_ff <= qx_in;
         qz_ff <= $signed(rho_tag.side);
      end
   end

   // Clamped positive excesses and the inside term min(max(qx, qz), 0).
   tag_type                     part_tag_ff, part_tag_in;
   logic [MAG_BITS-1:0]         ox_ff, ox_in;
   logic [MAG_BITS-1:0]         oz_ff, oz_in;
   logic signed [SIDE_BITS-1:0] near;

   always_comb begin
      priority if (qx_ff > LIM) begin
         ox_in = MAG_BITS'(LIM);
      end else if (qx_ff > 0) begin
         ox_in = MAG_BITS'(qx_ff);
      end else begin
         ox_in = '0;
      end
      priority if (qz_ff > LIM) begin
         oz_in = MAG_BITS'(LIM);
      end else if (qz_ff > 0) begin
         oz_in = MAG_BITS'(qz_ff);
      end else begin
         oz_in = '0;
      end
      near              = (qx_ff > qz_ff) ? qx_ff : qz_ff;
      part_tag_in.valid = ex_valid_ff;
      part_tag_in.side  = (near > 0) ? '0 : near;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         part_tag_ff.valid <= 1'b0;
      end else if (en) begin
         part_tag_ff <= part_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ox_ff <= ox_in;
         oz_ff <= oz_in;
      end
   end

   // Outside distance = floor(sqrt(ox*ox + oz*oz)).
   tag_type              osq_tag;
   logic [SQ_BITS-1:0]   osq;
   tag_type              out_tag;
   logic [ROOT_BITS-1:0] outside;

   tsd_sumsq u_out_sumsq (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_tag  (part_tag_ff),
      .a       (ox_ff),
      .b       (oz_ff),
      .out_tag (osq_tag),
      .sum     (osq)
   );

   tsd_sqrt u_out_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_tag   (osq_tag),
      .radicand (osq),
      .out_tag  (out_tag),
      .root     (outside)
   );

   // Final sum, saturated to the signed word, into the output register.
   logic signed [SIDE_BITS-1:0] total;

   always_comb begin
      total = $signed({2'b00, outside}) + $signed(out_tag.side);
      priority if (total > WMAX) begin
         dist_in = WORD_BITS'(WMAX);
      end else if (total < WMIN) begin
         dist_in = WORD_BITS'(WMIN);
      end else begin
         dist_in = WORD_BITS'(total);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= out_tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dist_ff <= dist_in;
      end
   end

   assign rsp.valid           = out_valid_ff;
   assign rsp.signed_distance = dist_ff;

endmodule

`default_nettype wire
